// ===== rtl/caa2_pkg.sv =====
// ----------------------------------------------------------------------------
// caa2_pkg: shared definitions for the complex argument core
// Angle formats, the arctangent table of the rotation cells, and the quadrant
// codes that travel with each item down the cell chain.
// ----------------------------------------------------------------------------
package caa2_pkg;

  localparam int GUARD_BITS = 24;
  localparam int ANGLE_FRAC = 20;
  localparam int OUT_FRAC   = 13;
  localparam int TABLE_LEN  = 24;
  localparam int ZW         = 24;
  localparam int ANGLE_W    = 16;
  localparam int ATAN_W     = 21;

  localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294199;
  localparam logic signed [ZW-1:0] PI_Q13 = 24'sd25736;
  localparam logic signed [ZW-1:0] HALF_PI_Q13 = 24'sd12868;

  localparam logic [ATAN_W-1:0] ATAN_Q20 [TABLE_LEN] = '{
    21'd823550, 21'd486170, 21'd256879, 21'd130396, 21'd65451, 21'd32757,
    21'd16383,  21'd8192,   21'd4096,   21'd2048,   21'd1024,  21'd512,
    21'd256,    21'd128,    21'd64,     21'd32,     21'd16,    21'd8,
    21'd4,      21'd2,      21'd1,      21'd0,      21'd0,     21'd0
  };

  typedef enum logic [2:0] {
    MODE_POS,
    MODE_NEG_UP,
    MODE_NEG_DN,
    MODE_PI,
    MODE_HALF_PI,
    MODE_NEG_HALF_PI,
    MODE_ZERO
  } caa2_mode_t;

  typedef struct packed {
    logic       valid;
    caa2_mode_t mode;
  } caa2_ctrl_t;

endpackage

// ===== rtl/caa2_cell.sv =====
// ----------------------------------------------------------------------------
// caa2_cell: one vectoring rotation of the arctangent chain
// Rotates the vector toward the real axis by atan(2^-STAGE), accumulates the
// angle, and registers the result for the next cell when the chain advances.
// ----------------------------------------------------------------------------
module caa2_cell #(
  parameter int XW    = 43,
  parameter int STAGE = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  caa2_pkg::caa2_ctrl_t            ctrl_i,
  input  logic signed [XW-1:0]            x_i,
  input  logic signed [XW-1:0]            y_i,
  input  logic signed [caa2_pkg::ZW-1:0]  z_i,
  output caa2_pkg::caa2_ctrl_t            ctrl_o,
  output logic signed [XW-1:0]            x_o,
  output logic signed [XW-1:0]            y_o,
  output logic signed [caa2_pkg::ZW-1:0]  z_o
);
  import caa2_pkg::*;

  localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_Q20[STAGE]);

  caa2_ctrl_t              ctrl_r;
  logic signed [XW-1:0]    x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [ZW-1:0]    z_r, z_nxt;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!y_i[XW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ANG;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctrl_o = ctrl_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;

endmodule

// ===== rtl/complex_argument_atan2_core.sv =====
// ----------------------------------------------------------------------------
// complex_argument_atan2_core: four-quadrant argument of a complex value
// Returns atan2(imag, real) in Q13 radians through a pipelined CORDIC chain.
// ----------------------------------------------------------------------------
// The core takes one item per cycle unless the chain holds, and returns its angle
// through one entry register that folds the real part into the right
// half plane, one rotation cell per iteration, and one output register that
// applies the quadrant correction, rounding and saturation. When the output
// item is not taken, the whole chain holds and in_ready drops. The angle is
// in radians with 13 fractional bits.
module complex_argument_atan2_core #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [DATA_WIDTH-1:0]          in_real_part,
  input  logic signed [DATA_WIDTH-1:0]          in_imag_part,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [caa2_pkg::ANGLE_W-1:0]   out_angle
);
  import caa2_pkg::*;

  localparam int XW = DATA_WIDTH + GUARD_BITS + 3;
  localparam int RSH = ANGLE_FRAC - OUT_FRAC;
  localparam logic signed [ZW-1:0] ROUND = ZW'(1) <<< (RSH - 1);

  logic                   en;
  caa2_ctrl_t             ctrl_s [ITERATIONS+1];
  logic signed [XW-1:0]   x_s    [ITERATIONS+1];
  logic signed [XW-1:0]   y_s    [ITERATIONS+1];
  logic signed [ZW-1:0]   z_s    [ITERATIONS+1];

  caa2_ctrl_t             ctrl_r, ctrl_nxt;
  logic signed [XW-1:0]   x_r, y_r, x_nxt, y_nxt, a_ext;
  logic                   a_neg, a_zero, b_neg, b_zero;

  logic                   out_valid_r;
  logic signed [ANGLE_W-1:0] angle_r, angle_nxt;
  logic signed [ZW-1:0]   zc, zr, r;
  caa2_ctrl_t             last;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    a_neg  = in_real_part[DATA_WIDTH-1];
    a_zero = (in_real_part == '0);
    b_neg  = in_imag_part[DATA_WIDTH-1];
    b_zero = (in_imag_part == '0);
    a_ext  = XW'(in_real_part);
    x_nxt  = (a_neg ? -a_ext : a_ext) <<< GUARD_BITS;
    y_nxt  = XW'(in_imag_part) <<< GUARD_BITS;
    ctrl_nxt.valid = in_valid;
    if (!a_neg && !a_zero) begin
      ctrl_nxt.mode = MODE_POS;
    end else if (a_neg) begin
      if (b_zero) begin
        ctrl_nxt.mode = MODE_PI;
      end else if (b_neg) begin
        ctrl_nxt.mode = MODE_NEG_DN;
      end else begin
        ctrl_nxt.mode = MODE_NEG_UP;
      end
    end else if (b_neg) begin
      ctrl_nxt.mode = MODE_NEG_HALF_PI;
    end else if (b_zero) begin
      ctrl_nxt.mode = MODE_ZERO;
    end else begin
      ctrl_nxt.mode = MODE_HALF_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  assign ctrl_s[0] = ctrl_r;
  assign x_s[0]    = x_r;
  assign y_s[0]    = y_r;
  assign z_s[0]    = '0;

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    caa2_cell #(
      .XW    (XW),
      .STAGE (k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctrl_i (ctrl_s[k]),
      .x_i    (x_s[k]),
      .y_i    (y_s[k]),
      .z_i    (z_s[k]),
      .ctrl_o (ctrl_s[k+1]),
      .x_o    (x_s[k+1]),
      .y_o    (y_s[k+1]),
      .z_o    (z_s[k+1])
    );
  end

  assign last = ctrl_s[ITERATIONS];

  always_comb begin
    case (last.mode)
      MODE_NEG_UP: zc = PI_Q20 - z_s[ITERATIONS];
      MODE_NEG_DN: zc = -PI_Q20 - z_s[ITERATIONS];
      default:     zc = z_s[ITERATIONS];
    endcase
    zr = (zc + ROUND) >>> RSH;
    if (zr > PI_Q13) begin
      r = PI_Q13;
    end else if (zr < -PI_Q13) begin
      r = -PI_Q13;
    end else begin
      r = zr;
    end
    case (last.mode)
      MODE_PI:          angle_nxt = ANGLE_W'(PI_Q13);
      MODE_HALF_PI:     angle_nxt = ANGLE_W'(HALF_PI_Q13);
      MODE_NEG_HALF_PI: angle_nxt = ANGLE_W'(-HALF_PI_Q13);
      MODE_ZERO:        angle_nxt = '0;
      default:          angle_nxt = ANGLE_W'(r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle = angle_r;

endmodule

// ===== bench/caa2_angle_checker.sv =====
// ----------------------------------------------------------------------------
// caa2_angle_checker: angle predictor and scoreboard for the argument core
// Watches both channels of the core. Every accepted input item is turned into
// its expected Q13 angle with a CORDIC vectoring model of its own, and every
// accepted result is compared with the oldest expected angle in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module caa2_angle_checker #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [DATA_WIDTH-1:0]        in_real_part,
  input  logic signed [DATA_WIDTH-1:0]        in_imag_part,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [caa2_pkg::ANGLE_W-1:0] out_angle,
  output int                                  fail_count,
  output int                                  pending_count
);

  localparam int SCALE_BITS = 24;
  localparam int Z_FRAC     = 20;
  localparam int A_FRAC     = 13;
  localparam int ROM_LEN    = 24;
  localparam longint PI_Z   = 64'sd3294199;
  localparam longint PI_A   = 64'sd25736;
  localparam longint HALF_A = 64'sd12868;
  localparam int REPORT_MAX = 10;

  localparam longint ARCTAN_Z [ROM_LEN] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0, 0, 0
  };

  typedef struct {
    logic signed [DATA_WIDTH-1:0]        re;
    logic signed [DATA_WIDTH-1:0]        im;
    logic signed [caa2_pkg::ANGLE_W-1:0] angle;
  } angle_entry_t;

  angle_entry_t expected_angles [$];
  int           report_count;

  function automatic longint vector_angle(longint x0, longint y0);
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint z;
    int     i;
    x = x0 * (64'sd1 <<< SCALE_BITS);
    y = y0 * (64'sd1 <<< SCALE_BITS);
    z = 0;
    for (i = 0; i < ITERATIONS && i < ROM_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_Z[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_Z[i];
      end
    end
    return z;
  endfunction

  function automatic logic signed [caa2_pkg::ANGLE_W-1:0] predict_angle(
    logic signed [DATA_WIDTH-1:0] re,
    logic signed [DATA_WIDTH-1:0] im
  );
    longint a;
    longint b;
    longint z;
    longint r;
    a = re;
    b = im;
    if (a > 0 || (a < 0 && b != 0)) begin
      if (a > 0) begin
        z = vector_angle(a, b);
      end else begin
        z = vector_angle(-a, b);
        z = (b > 0) ? (PI_Z - z) : (-PI_Z - z);
      end
      r = (z + (64'sd1 <<< (Z_FRAC - A_FRAC - 1))) >>> (Z_FRAC - A_FRAC);
      if (r > PI_A) r = PI_A;
      if (r < -PI_A) r = -PI_A;
    end else if (a < 0) begin
      r = PI_A;
    end else if (b < 0) begin
      r = -HALF_A;
    end else if (b > 0) begin
      r = HALF_A;
    end else begin
      r = 0;
    end
    return r[caa2_pkg::ANGLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    angle_entry_t e;
    if (!rst_n) begin
      expected_angles.delete();
      fail_count    <= 0;
      pending_count <= 0;
      report_count  = 0;
    end else begin
      if (in_valid && in_ready) begin
        e.re    = in_real_part;
        e.im    = in_imag_part;
        e.angle = predict_angle(in_real_part, in_imag_part);
        expected_angles.push_back(e);
      end
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          fail_count <= fail_count + 1;
          if (report_count < REPORT_MAX)
            $display("[%0t] unexpected result: angle %0d", $realtime, out_angle);
          report_count++;
        end else begin
          e = expected_angles.pop_front();
          if (out_angle !== e.angle) begin
            fail_count <= fail_count + 1;
            if (report_count < REPORT_MAX)
              $display("[%0t] angle mismatch: real %0d imag %0d expected %0d got %0d",
                       $realtime, e.re, e.im, e.angle, out_angle);
            report_count++;
          end
        end
      end
      pending_count <= expected_angles.size();
    end
  end

endmodule

// ===== bench/tb_complex_argument_atan2_core.sv =====
// ----------------------------------------------------------------------------
// tb_complex_argument_atan2_core: testbench for the complex argument core
// Drives directed corner points and random complex values with random gaps on
// both channels, a long output stall and a full drain, and reports the verdict
// from the failure count of the angle checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_complex_argument_atan2_core;

  localparam int DW         = 16;
  localparam int ITER       = 16;
  localparam int RAND_ITEMS = 1400;
  localparam int DRAIN_WAIT = 40;
  localparam int HOLD_LEN   = 250;
  localparam int HOLD_AT    = 400;
  localparam int PAUSE_AT   = 900;
  localparam int BURST_LO   = 600;
  localparam int BURST_HI   = 700;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [DW-1:0]                in_real_part;
  logic signed [DW-1:0]                in_imag_part;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [caa2_pkg::ANGLE_W-1:0] out_angle;
  int                                  fail_count;
  int                                  pending_count;
  logic                                in_fire_q;
  logic                                out_fire_q;
  int                                  item_idx;
  int                                  result_idx;
  bit                                  hold_done;

  complex_argument_atan2_core #(
    .DATA_WIDTH(DW),
    .ITERATIONS(ITER)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_real_part(in_real_part),
    .in_imag_part(in_imag_part),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_angle   (out_angle)
  );

  caa2_angle_checker #(
    .DATA_WIDTH(DW),
    .ITERATIONS(ITER)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_real_part (in_real_part),
    .in_imag_part (in_imag_part),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_angle    (out_angle),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    in_fire_q  <= in_valid && in_ready;
    out_fire_q <= out_valid && out_ready;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic offer_item(input int re, input int im);
    int gap;
    gap = (item_idx >= BURST_LO && item_idx < BURST_HI) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_real_part <= re[DW-1:0];
    in_imag_part <= im[DW-1:0];
    do @(negedge clk); while (!in_fire_q);
    item_idx++;
  endtask

  initial begin : receiver
    int gap;
    out_ready  = 1'b0;
    result_idx = 0;
    hold_done  = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (!hold_done && result_idx >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      gap = (result_idx >= BURST_LO && result_idx < BURST_HI) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_fire_q);
      result_idx++;
    end
  end

  initial begin : sender
    int k;
    int re;
    int im;
    int corner [5];
    corner       = '{-32768, -1, 0, 1, 32767};
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_real_part = '0;
    in_imag_part = '0;
    item_idx     = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    offer_item(0, 0);
    offer_item(1, 0);
    offer_item(-1, 0);
    offer_item(0, 1);
    offer_item(0, -1);
    offer_item(32767, 0);
    offer_item(-32768, 0);
    offer_item(0, 32767);
    offer_item(0, -32768);
    offer_item(32767, 32767);
    offer_item(-32768, -32768);
    offer_item(-32768, 32767);
    offer_item(32767, -32768);
    offer_item(-1, 1);
    offer_item(-1, -1);
    offer_item(-32768, 1);
    offer_item(-32768, -1);
    offer_item(1, -32768);
    offer_item(1, 32767);
    offer_item(-1, -32768);
    offer_item(5, -5);
    offer_item(-5, 5);
    offer_item(32767, 1);
    offer_item(100, -1);

    for (k = 0; k < RAND_ITEMS; k++) begin
      if (item_idx == PAUSE_AT) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
      end
      case ($urandom_range(0, 9))
        6: begin
          re = $urandom_range(0, 8) - 4;
          im = $urandom_range(0, 8) - 4;
        end
        7: begin
          re = $urandom();
          im = 0;
          if ($urandom_range(0, 1)) begin
            im = re;
            re = 0;
          end
        end
        8: begin
          re = -$urandom_range(1, 32768);
          im = $urandom_range(0, 6) - 3;
        end
        9: begin
          re = corner[$urandom_range(0, 4)];
          im = corner[$urandom_range(0, 4)];
        end
        default: begin
          re = $urandom();
          im = $urandom();
        end
      endcase
      offer_item(re, im);
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
